[design/wilder_rsi_stream_assert.svh]
// Assertion macros shared by the RSI stream design files.
`ifndef WILDER_RSI_STREAM_ASSERT_SVH
`define WILDER_RSI_STREAM_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition in the same cycle as its trigger.
`define WRSI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define WRSI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define WRSI_ASSERT_NOW(lbl, ante, cons, msg)
`define WRSI_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/wrsi_pkg.sv]
// Types and constants shared by the RSI stream modules.
package wrsi_pkg;

    localparam int PRICE_BITS    = 32;
    localparam int FRACTION_BITS = 16;
    localparam int AVG_BITS      = PRICE_BITS + FRACTION_BITS;
    localparam int PERIOD_BITS   = 8;
    localparam int ITEMS_BITS    = PERIOD_BITS + 1;
    localparam int RSI_BITS      = 14;
    localparam int PROD_BITS     = AVG_BITS + PERIOD_BITS;
    localparam int DVD_BITS      = AVG_BITS + RSI_BITS;
    localparam int DVS_BITS      = AVG_BITS + 1;
    localparam int REM_BITS      = DVS_BITS + 1;
    localparam int QUOT_BITS     = AVG_BITS;
    localparam int CNT_BITS      = $clog2(QUOT_BITS + 1);

    localparam logic [RSI_BITS-1:0]    RSI_FULL_SCALE = RSI_BITS'(10000);
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET   = PERIOD_BITS'(14);

    typedef enum logic {
        DIV_AVG,
        DIV_RSI
    } t_div_mode;

    typedef struct packed {
        logic      start;
        t_div_mode mode;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BRANCH,
        S_PREP,
        S_START,
        S_WAIT,
        S_RMUL,
        S_RSTART,
        S_RWAIT,
        S_PUT
    } t_state;

endpackage

[design/wrsi_div.sv]
// Shared restoring divider, one quotient bit per cycle.
`include "wilder_rsi_stream_assert.svh"

module wrsi_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wrsi_pkg::t_div_ctl                  i_ctl,
    input  logic [wrsi_pkg::DVD_BITS-1:0]       i_dividend,
    input  logic [wrsi_pkg::DVS_BITS-1:0]       i_divisor,
    output wrsi_pkg::t_div_sts                  o_sts,
    output logic [wrsi_pkg::QUOT_BITS-1:0]      o_quot
);
    import wrsi_pkg::*;

    logic [REM_BITS-1:0]  r_rem;
    logic [REM_BITS-1:0]  n_rem;
    logic [QUOT_BITS-1:0] r_q;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [REM_BITS-1:0]  w_trial;
    logic [REM_BITS-1:0]  w_dvs_ext;
    logic                 n_bit;

    assign w_dvs_ext = REM_BITS'(i_divisor);
    // Remainder stays below the divisor, so its top bit is always free.
    assign w_trial   = {r_rem[REM_BITS-2:0], r_q[QUOT_BITS-1]};

    always_comb begin
        n_bit = (w_trial >= w_dvs_ext);
        n_rem = n_bit ? (w_trial - w_dvs_ext) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                if (i_ctl.mode == DIV_RSI) begin
                    // Quotient fits in RSI_BITS: preload the high part as remainder.
                    r_rem <= REM_BITS'(i_dividend[DVD_BITS-1:RSI_BITS]);
                    r_q   <= {i_dividend[RSI_BITS-1:0], (QUOT_BITS-RSI_BITS)'(0)};
                    r_cnt <= CNT_BITS'(RSI_BITS);
                end else begin
                    r_rem <= REM_BITS'(i_dividend[DVD_BITS-1:QUOT_BITS]);
                    r_q   <= i_dividend[QUOT_BITS-1:0];
                    r_cnt <= CNT_BITS'(QUOT_BITS);
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[QUOT_BITS-2:0], n_bit};
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

    `WRSI_ASSERT_NOW(a_done_not_busy, r_done, !r_busy, "divider done while busy")
    `WRSI_ASSERT_NOW(a_start_idle, i_ctl.start, !r_busy, "divider restarted while busy")
    `WRSI_ASSERT_NOW(a_rem_bound, r_busy, r_rem < w_dvs_ext, "remainder not below divisor")

endmodule

[design/wilder_rsi_stream.sv]
// Wilder RSI over a stream of closing prices, one shared divider under a sequencer.
// Warm-up closes pass S_BRANCH and S_PUT; the next close can be taken as the result turns valid.
// Full closes: two 48-bit average divisions and one 14-bit ratio division in the divider,
// the ratio division skipped when the average loss is zero.
// A close is accepted only while the sequencer is idle; a waiting result does not block it.
// Reset is synchronous, active low: period returns to 14 and all stream state clears.
`include "wilder_rsi_stream_assert.svh"

module wilder_rsi_stream (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wrsi_pkg::PERIOD_BITS-1:0]    i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [wrsi_pkg::PRICE_BITS-1:0]     i_close_price,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [wrsi_pkg::RSI_BITS-1:0]       o_rsi_value,
    output logic                                o_rsi_valid
);
    import wrsi_pkg::*;

    t_state                 r_state;
    t_state                 n_state;

    logic [PERIOD_BITS-1:0] r_period;
    logic [PRICE_BITS-1:0]  r_prev;
    logic [ITEMS_BITS-1:0]  r_items;
    logic [AVG_BITS-1:0]    r_gain;
    logic [AVG_BITS-1:0]    r_loss;

    logic [PRICE_BITS-1:0]  r_up;
    logic [PRICE_BITS-1:0]  r_down;
    logic                   r_first;
    logic                   r_sel;
    logic [DVD_BITS-1:0]    r_num;
    logic [DVS_BITS-1:0]    r_den;
    logic [RSI_BITS-1:0]    r_value;
    logic                   r_valid;

    logic                   r_out_valid;
    logic [RSI_BITS-1:0]    r_out_value;
    logic                   r_out_rsi_valid;

    logic [PERIOD_BITS-1:0] w_p;
    logic [PERIOD_BITS-1:0] w_pm1;
    logic [ITEMS_BITS-1:0]  w_p_ext;
    logic [ITEMS_BITS-1:0]  w_items_max;
    logic                   w_accept;
    logic                   w_slot_free;
    logic [AVG_BITS-1:0]    w_avg_sel;
    logic [PRICE_BITS-1:0]  w_chg_sel;
    logic [PROD_BITS-1:0]   w_prod;
    logic [DVD_BITS-1:0]    w_chg_scaled;
    logic [DVD_BITS-1:0]    w_dividend;
    logic [DVD_BITS-1:0]    w_rsi_num;

    t_div_ctl               w_div_ctl;
    t_div_sts               w_div_sts;
    logic [QUOT_BITS-1:0]   w_quot;

    // A period of zero acts as one.
    assign w_p         = (r_period == '0) ? PERIOD_BITS'(1) : r_period;
    assign w_pm1       = w_p - PERIOD_BITS'(1);
    assign w_p_ext     = ITEMS_BITS'(w_p);
    assign w_items_max = w_p_ext + ITEMS_BITS'(1);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_avg_sel    = r_sel ? r_loss : r_gain;
    assign w_chg_sel    = r_sel ? r_down : r_up;
    assign w_prod       = PROD_BITS'(w_avg_sel) * PROD_BITS'(w_pm1);
    assign w_chg_scaled = DVD_BITS'(w_chg_sel) << FRACTION_BITS;
    assign w_rsi_num    = DVD_BITS'(r_gain) * DVD_BITS'(RSI_FULL_SCALE);

    wrsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (r_den),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_BRANCH;
            end
            S_BRANCH: begin
                n_state = (r_items < w_p_ext) ? S_PUT : S_PREP;
            end
            S_PREP:   n_state = S_START;
            S_START:  n_state = S_WAIT;
            S_WAIT: begin
                if (w_div_sts.done) n_state = r_sel ? S_RMUL : S_PREP;
            end
            S_RMUL: begin
                n_state = (r_loss == '0) ? S_PUT : S_RSTART;
            end
            S_RSTART: n_state = S_RWAIT;
            S_RWAIT: begin
                if (w_div_sts.done) n_state = S_PUT;
            end
            S_PUT: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_div_ctl.mode  = DIV_AVG;
        w_dividend      = r_first ? (r_num << FRACTION_BITS) : (r_num + w_chg_scaled);
        unique case (r_state)
            S_IDLE:   o_in_ready = 1'b1;
            S_START:  w_div_ctl.start = 1'b1;
            S_RSTART: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.mode  = DIV_RSI;
                w_dividend      = r_num;
            end
            default: begin
                o_in_ready      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Stream state: period, previous close, count and averages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_prev   <= '0;
            r_items  <= '0;
            r_gain   <= '0;
            r_loss   <= '0;
        end else if (i_cfg_we) begin
            // Restart warm-up on every period write.
            r_period <= i_cfg_wdata;
            r_prev   <= '0;
            r_items  <= '0;
            r_gain   <= '0;
            r_loss   <= '0;
        end else begin
            if (w_accept) begin
                r_prev <= i_close_price;
            end
            if (r_state == S_BRANCH) begin
                if (r_items == '0) begin
                    r_items <= ITEMS_BITS'(1);
                end else if (r_items < w_p_ext) begin
                    r_gain  <= r_gain + AVG_BITS'(r_up);
                    r_loss  <= r_loss + AVG_BITS'(r_down);
                    r_items <= r_items + ITEMS_BITS'(1);
                end else begin
                    r_items <= w_items_max;
                end
            end
            if (r_state == S_WAIT && w_div_sts.done) begin
                if (r_sel) begin
                    r_loss <= w_quot;
                end else begin
                    r_gain <= w_quot;
                end
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_up   <= (i_close_price > r_prev) ? (i_close_price - r_prev) : '0;
            r_down <= (r_prev > i_close_price) ? (r_prev - i_close_price) : '0;
        end
        unique case (r_state)
            S_BRANCH: begin
                r_first <= (r_items == w_p_ext);
                r_sel   <= 1'b0;
                r_value <= '0;
                r_valid <= 1'b0;
            end
            S_PREP: begin
                // First average divides the sum; later ones smooth the old average.
                r_num <= r_first ? DVD_BITS'(w_avg_sel + AVG_BITS'(w_chg_sel))
                                 : DVD_BITS'(w_prod);
                r_den <= DVS_BITS'(w_p);
            end
            S_WAIT: begin
                if (w_div_sts.done) r_sel <= 1'b1;
            end
            S_RMUL: begin
                r_num   <= w_rsi_num;
                r_den   <= DVS_BITS'(r_gain) + DVS_BITS'(r_loss);
                r_value <= RSI_FULL_SCALE;
                r_valid <= 1'b1;
            end
            S_RWAIT: begin
                if (w_div_sts.done) r_value <= w_quot[RSI_BITS-1:0];
            end
            default: begin
                r_valid <= r_valid;
            end
        endcase
    end

    // Output register: hold the transaction until taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_PUT && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PUT && w_slot_free) begin
            r_out_value     <= r_value;
            r_out_rsi_valid <= r_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_rsi_value = r_out_value;
    assign o_rsi_valid = r_out_rsi_valid;

    `WRSI_ASSERT_NOW(a_warmup_zero, o_out_valid && !o_rsi_valid, o_rsi_value == '0, "warm-up value")
    `WRSI_ASSERT_NOW(a_rsi_range, o_out_valid, o_rsi_value <= RSI_FULL_SCALE, "RSI above full scale")
    `WRSI_ASSERT_NOW(a_items_bound, 1'b1, r_items <= w_items_max, "item count beyond period plus one")
    `WRSI_ASSERT_NEXT(a_one_at_a_time, w_accept, !o_in_ready, "second close taken while busy")

endmodule

[dv/testbench.sv]
// Self-checking testbench for the Wilder RSI stream block.
`timescale 1ns / 1ps

module testbench;
    import wrsi_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = '1;

    // Predicts the RSI for each accepted close and holds the results still owed.
    class t_rsi_scoreboard;
        typedef struct packed {
            logic [RSI_BITS-1:0] value;
            logic                valid;
        } t_rsi_result;

        logic [PERIOD_BITS-1:0] period;
        logic [PRICE_BITS-1:0]  last_close;
        int unsigned            closes_seen;
        logic [63:0]            avg_gain;
        logic [63:0]            avg_loss;
        t_rsi_result            pending_rsi[$];
        int unsigned            mismatches;

        function new();
            period     = PERIOD_RESET;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            last_close  = '0;
            closes_seen = 0;
            avg_gain    = '0;
            avg_loss    = '0;
        endfunction

        function void set_period(logic [PERIOD_BITS-1:0] p);
            period = p;
            restart();
        endfunction

        function logic [63:0] first_avg(logic [63:0] sum, int unsigned p);
            return ((sum / p) << FRACTION_BITS) + (((sum % p) << FRACTION_BITS) / p);
        endfunction

        function logic [63:0] smooth(logic [63:0] avg, logic [63:0] change, int unsigned p);
            return (avg * (p - 1) + (change << FRACTION_BITS)) / p;
        endfunction

        function logic [RSI_BITS-1:0] rsi_of(logic [63:0] g, logic [63:0] l);
            if (l == 0) begin
                return RSI_FULL_SCALE;
            end
            return RSI_BITS'((g * RSI_FULL_SCALE) / (g + l));
        endfunction

        function void note_close(logic [PRICE_BITS-1:0] px);
            int unsigned p;
            logic [63:0] rise;
            logic [63:0] fall;
            t_rsi_result res;
            // A period of zero behaves as one.
            p    = (period == 0) ? 1 : period;
            rise = (px > last_close) ? 64'(px - last_close) : 64'd0;
            fall = (last_close > px) ? 64'(last_close - px) : 64'd0;
            res  = '0;
            if (closes_seen == 0) begin
                closes_seen = 1;
            end else if (closes_seen < p) begin
                avg_gain += rise;
                avg_loss += fall;
                closes_seen++;
            end else begin
                if (closes_seen == p) begin
                    avg_gain = first_avg(avg_gain + rise, p);
                    avg_loss = first_avg(avg_loss + fall, p);
                end else begin
                    avg_gain = smooth(avg_gain, rise, p);
                    avg_loss = smooth(avg_loss, fall, p);
                end
                closes_seen = p + 1;
                res.value   = rsi_of(avg_gain, avg_loss);
                res.valid   = 1'b1;
            end
            last_close = px;
            pending_rsi.push_back(res);
        endfunction

        function void check_rsi(logic [RSI_BITS-1:0] value, logic valid);
            t_rsi_result want;
            if (pending_rsi.size() == 0) begin
                $error("rsi_value: no result expected, actual %0d (rsi_valid %0b)",
                       value, valid);
                mismatches++;
                return;
            end
            want = pending_rsi.pop_front();
            if (want.value !== value) begin
                $error("rsi_value: expected %0d, actual %0d", want.value, value);
                mismatches++;
            end
            if (want.valid !== valid) begin
                $error("rsi_valid: expected %0b, actual %0b", want.valid, valid);
                mismatches++;
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [PERIOD_BITS-1:0] i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [PRICE_BITS-1:0]  i_close_price;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [RSI_BITS-1:0]    o_rsi_value;
    logic                   o_rsi_valid;

    t_rsi_scoreboard rsi_board;
    int unsigned     closes_sent = 0;
    int unsigned     sender_idle_pct = 18;
    int unsigned     receiver_idle_pct = 63;
    int unsigned     cycle_count = 0;

    wilder_rsi_stream dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_close_price (i_close_price),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rsi_value   (o_rsi_value),
        .o_rsi_valid   (o_rsi_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Drop valid and hold until every owed result has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (rsi_board.pending_rsi.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_BITS-1:0] p);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        rsi_board.set_period(p);
    endtask

    task automatic send_close(input logic [PRICE_BITS-1:0] px);
        if (closes_sent < 570) begin
            sender_idle_pct   = 18;
            receiver_idle_pct = 63;
        end else if (closes_sent < 1140) begin
            sender_idle_pct   = 63;
            receiver_idle_pct = 18;
        end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        // Mostly short gaps; now and then a long one so gaps land mid-computation.
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(1, 130) : 1) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_close_price <= px;
        do @(posedge i_clk); while (!o_in_ready);
        rsi_board.note_close(px);
        closes_sent++;
    endtask

    // Random-walk price stream with trending runs, jumps and rail values.
    task automatic run_stream(input logic [PERIOD_BITS-1:0] p, input int count,
                              input int pause_at);
        logic [PRICE_BITS-1:0] px;
        logic [PRICE_BITS-1:0] step;
        logic                  rising;
        int unsigned           step_cap;
        int                    trend;
        int                    run_left;
        px       = $urandom;
        run_left = 0;
        step_cap = 1;
        trend    = 0;
        write_period(p);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) begin
                drain();
            end
            if (run_left == 0) begin
                run_left = $urandom_range(1, 40);
                trend    = int'($urandom_range(0, 2)) - 1;
                step_cap = 32'd1 << $urandom_range(0, 31);
            end
            run_left--;
            case ($urandom_range(0, 19))
                0, 1: px = $urandom;
                2: px = '0;
                3: px = PRICE_MAX;
                default: begin
                    step = $urandom_range(0, step_cap);
                    if (trend > 0) begin
                        rising = ($urandom_range(0, 9) < 8);
                    end else if (trend < 0) begin
                        rising = ($urandom_range(0, 9) < 2);
                    end else begin
                        rising = 1'($urandom_range(0, 1));
                    end
                    if (rising) begin
                        px = (px > PRICE_MAX - step) ? PRICE_MAX : px + step;
                    end else begin
                        px = (px < step) ? '0 : px - step;
                    end
                end
            endcase
            send_close(px);
        end
    endtask

    // Result side: random stalls, some of them long.
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                rsi_board.check_rsi(o_rsi_value, o_rsi_valid);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < receiver_idle_pct) begin
                stall_left  = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 130) : 0;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [PRICE_BITS-1:0] swing_closes[16];
        logic [PRICE_BITS-1:0] flat_closes[4];
        logic [PRICE_BITS-1:0] rail_closes[3];

        swing_closes = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'h0000_0001, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000,
            32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678
        };
        flat_closes   = '{32'd5, 32'd10, 32'd10, 32'd9};
        rail_closes   = '{32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_in_valid    = 1'b0;
        i_close_price = '0;
        i_out_ready   = 1'b0;
        rsi_board     = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset period: full-scale swings through warm-up, first RSI and one smoothing step.
        foreach (swing_closes[k]) send_close(swing_closes[k]);
        // Period zero: only gains, then no movement at all, then a single loss.
        write_period(8'd0);
        foreach (flat_closes[k]) send_close(flat_closes[k]);
        // Period one: each change replaces the averages outright.
        write_period(8'd1);
        foreach (rail_closes[k]) send_close(rail_closes[k]);

        run_stream(8'd255, 420, -1);
        run_stream(8'd1, 200, -1);
        run_stream(8'd2, 200, -1);
        run_stream(PERIOD_BITS'($urandom_range(3, 20)), 250, 120);
        // Cut the warm-up short with the next period write.
        run_stream(8'd40, 20, -1);
        run_stream(8'd14, 230, -1);
        run_stream(PERIOD_BITS'($urandom_range(1, 255)), 180, -1);
        run_stream(8'd5, 200, -1);

        drain();
        repeat (16) @(posedge i_clk);
        if (rsi_board.mismatches == 0 && rsi_board.pending_rsi.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
